// ===== rtl/core/line_pixel_generator_unit_assert.svh =====
// assertion macros for the line pixel generator checker
// expects a clock named clk and a reset named rst in the using scope
`ifndef LINE_PIXEL_GENERATOR_UNIT_ASSERT_SVH
`define LINE_PIXEL_GENERATOR_UNIT_ASSERT_SVH

// same-cycle implication, off during reset
`define LPG_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, off during reset
`define LPG_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// next-cycle implication that also holds across reset
`define LPG_ASSERT_NEXT_ALWAYS(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/lpg_pkg.sv =====
// shared types and constants of the line pixel generator
// used by the interfaces and every module of the block
package lpg_pkg;

  localparam int COORD_BITS     = 9;
  localparam int OUT_BITS       = 10;
  localparam int COLOR_BITS     = 16;
  localparam int OFFSET_BITS    = 8;
  localparam int ERR_BITS       = COORD_BITS + 1;
  localparam int LEFT_BITS      = COORD_BITS + 1;
  localparam int QUEUE_DEPTH    = 2;
  localparam int QPTR_BITS      = $clog2(QUEUE_DEPTH);
  localparam int REG_INDEX_BITS = 1;

  localparam logic [REG_INDEX_BITS-1:0] REG_COLUMN_OFFSET = 1'b0;
  localparam logic [REG_INDEX_BITS-1:0] REG_ROW_OFFSET    = 1'b1;

  // step direction codes, two's complement
  localparam logic [1:0] DIR_NONE = 2'b00;
  localparam logic [1:0] DIR_POS  = 2'b01;
  localparam logic [1:0] DIR_NEG  = 2'b11;

  typedef enum logic {
    OP_START = 1'b0,
    OP_STEP  = 1'b1
  } op_t;

  // classified item as it waits between front and back
  typedef struct packed {
    op_t                   op;
    logic [COORD_BITS-1:0] start_x;
    logic [COORD_BITS-1:0] start_y;
    logic [1:0]            dir_x;
    logic [1:0]            dir_y;
    logic [COORD_BITS-1:0] delta_x;
    logic [COORD_BITS-1:0] delta_y;
    logic [COORD_BITS-1:0] distance;
    logic [COLOR_BITS-1:0] color;
  } lpg_entry_t;

endpackage

// ===== rtl/core/lpg_cmd_if.sv =====
// command channel and pixel channel of the line pixel generator
// depends on lpg_pkg
interface lpg_cmd_if import lpg_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic                  operation;
  logic [COORD_BITS-1:0] start_x;
  logic [COORD_BITS-1:0] start_y;
  logic [COORD_BITS-1:0] end_x;
  logic [COORD_BITS-1:0] end_y;
  logic [COLOR_BITS-1:0] pixel_color;

  modport source (output valid, operation, start_x, start_y, end_x, end_y, pixel_color,
                  input ready);
  modport sink (input valid, operation, start_x, start_y, end_x, end_y, pixel_color,
                output ready);
endinterface

interface lpg_pix_if import lpg_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [OUT_BITS-1:0]   column;
  logic [OUT_BITS-1:0]   row;
  logic [COLOR_BITS-1:0] color;
  logic                  last;

  modport source (output valid, column, row, color, last, input ready);
  modport sink (input valid, column, row, color, last, output ready);
endinterface

// ===== rtl/core/lpg_front.sv =====
// front end: accepts command items and works out direction, deltas and distance
// depends on lpg_pkg and lpg_cmd_if
module lpg_front import lpg_pkg::*; (
  lpg_cmd_if.sink    cmd,
  input  logic       q_full,
  output logic       q_push,
  output lpg_entry_t q_entry
);

  logic                  x_fwd;
  logic                  y_fwd;
  logic [COORD_BITS-1:0] delta_x;
  logic [COORD_BITS-1:0] delta_y;

  assign cmd.ready = !q_full;
  assign q_push    = cmd.valid && !q_full;

  assign x_fwd   = cmd.end_x >= cmd.start_x;
  assign y_fwd   = cmd.end_y >= cmd.start_y;
  assign delta_x = x_fwd ? cmd.end_x - cmd.start_x : cmd.start_x - cmd.end_x;
  assign delta_y = y_fwd ? cmd.end_y - cmd.start_y : cmd.start_y - cmd.end_y;

  always_comb begin
    q_entry.op       = op_t'(cmd.operation);
    q_entry.start_x  = cmd.start_x;
    q_entry.start_y  = cmd.start_y;
    q_entry.delta_x  = delta_x;
    q_entry.delta_y  = delta_y;
    q_entry.distance = (delta_x > delta_y) ? delta_x : delta_y;
    q_entry.color    = cmd.pixel_color;
    if (delta_x == '0) begin
      q_entry.dir_x = DIR_NONE;
    end else if (x_fwd) begin
      q_entry.dir_x = DIR_POS;
    end else begin
      q_entry.dir_x = DIR_NEG;
    end
    if (delta_y == '0) begin
      q_entry.dir_y = DIR_NONE;
    end else if (y_fwd) begin
      q_entry.dir_y = DIR_POS;
    end else begin
      q_entry.dir_y = DIR_NEG;
    end
  end

endmodule

// ===== rtl/core/lpg_queue.sv =====
// short queue of classified items between front and back
// depends on lpg_pkg
module lpg_queue import lpg_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  lpg_entry_t push_entry,
  output logic       full,
  input  logic       pop,
  output logic       head_valid,
  output lpg_entry_t head_entry
);

  lpg_entry_t           slots [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wr_ptr;
  logic [QPTR_BITS-1:0] rd_ptr;
  logic [QPTR_BITS:0]   count;

  assign full       = count == (QPTR_BITS+1)'(QUEUE_DEPTH);
  assign head_valid = count != '0;
  assign head_entry = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (!push && pop) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/core/lpg_back.sv =====
// back end: holds the line state, runs the error accumulators, drives pixels
// depends on lpg_pkg and lpg_pix_if
module lpg_back import lpg_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   q_valid,
  input  lpg_entry_t             q_entry,
  output logic                   q_pop,
  input  logic [OFFSET_BITS-1:0] column_offset,
  input  logic [OFFSET_BITS-1:0] row_offset,
  lpg_pix_if.source              pix
);

  logic                  active;
  logic [COORD_BITS-1:0] cur_x;
  logic [COORD_BITS-1:0] cur_y;
  logic [ERR_BITS-1:0]   err_x;
  logic [ERR_BITS-1:0]   err_y;
  logic [1:0]            dir_x;
  logic [1:0]            dir_y;
  logic [COORD_BITS-1:0] delta_x;
  logic [COORD_BITS-1:0] delta_y;
  logic [COORD_BITS-1:0] distance;
  logic [LEFT_BITS-1:0]  left;
  logic [COLOR_BITS-1:0] line_color;
  logic                  out_valid;

  logic                  out_free;
  logic                  is_start;
  logic                  emit;
  logic [ERR_BITS-1:0]   sum_x;
  logic [ERR_BITS-1:0]   sum_y;
  logic                  move_x;
  logic                  move_y;
  logic [COORD_BITS:0]   col_sum;
  logic [COORD_BITS:0]   row_sum;

  assign out_free = !out_valid || pix.ready;
  assign is_start = q_entry.op == OP_START;
  // a step with no line in progress is simply dropped
  assign q_pop    = q_valid && (is_start || !active || out_free);
  assign emit     = q_pop && !is_start && active;

  assign sum_x  = err_x + {1'b0, delta_x};
  assign sum_y  = err_y + {1'b0, delta_y};
  assign move_x = sum_x > {1'b0, distance};
  assign move_y = sum_y > {1'b0, distance};

  assign col_sum = {1'b0, cur_x} + (COORD_BITS+1)'(column_offset);
  assign row_sum = {1'b0, cur_y} + (COORD_BITS+1)'(row_offset);

  assign pix.valid = out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      active    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (q_pop && is_start) begin
        active <= 1'b1;
      end else if (emit && left == LEFT_BITS'(1)) begin
        active <= 1'b0;
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (pix.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_x      <= '0;
      cur_y      <= '0;
      err_x      <= '0;
      err_y      <= '0;
      dir_x      <= DIR_NONE;
      dir_y      <= DIR_NONE;
      delta_x    <= '0;
      delta_y    <= '0;
      distance   <= '0;
      left       <= '0;
      line_color <= '0;
    end else if (q_pop && is_start) begin
      cur_x      <= q_entry.start_x;
      cur_y      <= q_entry.start_y;
      err_x      <= '0;
      err_y      <= '0;
      dir_x      <= q_entry.dir_x;
      dir_y      <= q_entry.dir_y;
      delta_x    <= q_entry.delta_x;
      delta_y    <= q_entry.delta_y;
      distance   <= q_entry.distance;
      left       <= {1'b0, q_entry.distance} + 1'b1;
      line_color <= q_entry.color;
    end else if (emit) begin
      err_x <= move_x ? sum_x - {1'b0, distance} : sum_x;
      err_y <= move_y ? sum_y - {1'b0, distance} : sum_y;
      if (move_x) begin
        cur_x <= cur_x + {{(COORD_BITS-2){dir_x[1]}}, dir_x};
      end
      if (move_y) begin
        cur_y <= cur_y + {{(COORD_BITS-2){dir_y[1]}}, dir_y};
      end
      left <= left - 1'b1;
    end
  end

  // output register, loaded with the pixel as it was before the advance
  always_ff @(posedge clk) begin
    if (emit) begin
      pix.column <= OUT_BITS'(col_sum);
      pix.row    <= OUT_BITS'(row_sum);
      pix.color  <= line_color;
      pix.last   <= left == LEFT_BITS'(1);
    end
  end

endmodule

// ===== rtl/core/line_pixel_generator_unit.sv =====
// line pixel generator, top level
// depends on lpg_pkg, lpg_cmd_if, lpg_pix_if, lpg_front, lpg_queue, lpg_back
//
// usage:
//   cmd carries items: operation start loads endpoints and color and gives no
//   pixel, operation step gives the current pixel of the line and advances.
//   pix carries one pixel per step while a line is in progress, with last set
//   on the final one; distance+1 pixels per line. steps without a line are
//   dropped. write_enable/write_index/write_data set the column and row
//   offsets added to every pixel; write them only while the block is idle.
// path: a step accepted on cmd is written into a queue slot, popped by the back
//   end, and its pixel is loaded into the output register that drives pix.
// throughput: one item per cycle while no pixel is stalled on pix, set by the
//   single error accumulator update per cycle in the back end.
// reset: rst is synchronous; it drops any line in progress, empties the queue
//   and clears both offsets.
// stall: a pixel held on pix stalls the back end; the two-entry queue then
//   fills and cmd.ready falls. cmd.ready never depends on pix.ready in the
//   same cycle.
module line_pixel_generator_unit import lpg_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  lpg_cmd_if.sink                   cmd,
  lpg_pix_if.source                 pix,
  input  logic                      write_enable,
  input  logic [REG_INDEX_BITS-1:0] write_index,
  input  logic [OFFSET_BITS-1:0]    write_data
);

  logic                   q_push;
  logic                   q_full;
  logic                   q_pop;
  logic                   q_valid;
  lpg_entry_t             push_entry;
  lpg_entry_t             head_entry;
  logic [OFFSET_BITS-1:0] column_offset;
  logic [OFFSET_BITS-1:0] row_offset;

  always_ff @(posedge clk) begin
    if (rst) begin
      column_offset <= '0;
      row_offset    <= '0;
    end else if (write_enable) begin
      case (write_index)
        REG_COLUMN_OFFSET: column_offset <= write_data;
        REG_ROW_OFFSET:    row_offset    <= write_data;
        default: begin
        end
      endcase
    end
  end

  lpg_front u_front (
    .cmd     (cmd),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_entry (push_entry)
  );

  lpg_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_entry (head_entry)
  );

  lpg_back u_back (
    .clk           (clk),
    .rst           (rst),
    .q_valid       (q_valid),
    .q_entry       (head_entry),
    .q_pop         (q_pop),
    .column_offset (column_offset),
    .row_offset    (row_offset),
    .pix           (pix)
  );

endmodule

// ===== rtl/core/lpg_checker.sv =====
// port-level checks of the line pixel generator, bound to the top level
// depends on lpg_pkg and line_pixel_generator_unit_assert.svh
`include "line_pixel_generator_unit_assert.svh"

module lpg_checker import lpg_pkg::*; (
  input logic                  clk,
  input logic                  rst,
  input logic                  cmd_ready,
  input logic                  pix_valid,
  input logic                  pix_ready,
  input logic [OUT_BITS-1:0]   pix_column,
  input logic [OUT_BITS-1:0]   pix_row,
  input logic [COLOR_BITS-1:0] pix_color,
  input logic                  pix_last
);

  // no pixel may be pending right after reset
  `LPG_ASSERT_NEXT_ALWAYS(a_reset_clears_pix, rst, !pix_valid, "pixel valid after reset")

  // a stalled pixel keeps its payload
  `LPG_ASSERT_NEXT(a_pix_hold, pix_valid && !pix_ready, pix_valid && $stable(pix_column) && $stable(pix_row) && $stable(pix_color) && $stable(pix_last), "stalled pixel changed")

  // backpressure on cmd only comes from a stalled pixel
  `LPG_ASSERT_NOW(a_ready_without_stall, !pix_valid && $past(!pix_valid), cmd_ready, "cmd not ready with idle output")

endmodule

bind line_pixel_generator_unit lpg_checker u_lpg_checker (
  .clk        (clk),
  .rst        (rst),
  .cmd_ready  (cmd.ready),
  .pix_valid  (pix.valid),
  .pix_ready  (pix.ready),
  .pix_column (pix.column),
  .pix_row    (pix.row),
  .pix_color  (pix.color),
  .pix_last   (pix.last)
);
